/* sv/assert_macros.svh */
// Assertion helpers for the easing evaluator.
// Properties are clocked on clk and disabled while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define BEI_CHECK(name, prop) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("bei check failed");
`define BEI_CHECK_NEXT(name, cond, nxt) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (nxt)) \
        else $error("bei check failed");
`else
`define BEI_CHECK(name, prop)
`define BEI_CHECK_NEXT(name, cond, nxt)
`endif
`endif

/* sv/bei_pkg.sv */
package bei_pkg;

    localparam int NSAMPLES = 33;
    localparam int DUR_W = 20;
    localparam int POS_W = 16;
    localparam int TIME_W = 21;
    localparam int IDX_W = 5;
    localparam int Q10_W = 10;
    localparam int NDIV_IDX = 5;
    localparam int NDIV_FRAC = 7;
    localparam int Q10_FULL = 1023;

    localparam logic [1:0] CURVE_OUT = 2'd0;
    localparam logic [1:0] CURVE_IN = 2'd1;

    localparam logic [1:0] CFG_CURVE = 2'd0;
    localparam logic [1:0] CFG_DURATION = 2'd1;
    localparam logic [1:0] CFG_START = 2'd2;
    localparam logic [1:0] CFG_END = 2'd3;

    localparam logic [9:0] TBL_OUT [NSAMPLES] = '{
        10'd0, 10'd65, 10'd130, 10'd192, 10'd252, 10'd309, 10'd364, 10'd416,
        10'd466, 10'd513, 10'd558, 10'd600, 10'd640, 10'd678, 10'd713, 10'd747,
        10'd778, 10'd808, 10'd836, 10'd862, 10'd886, 10'd908, 10'd928, 10'd946,
        10'd962, 10'd976, 10'd988, 10'd996, 10'd1003, 10'd1009, 10'd1015, 10'd1020,
        10'd1023};

    localparam logic [9:0] TBL_IN [NSAMPLES] = '{
        10'd0, 10'd24, 10'd50, 10'd78, 10'd108, 10'd140, 10'd173, 10'd208,
        10'd244, 10'd282, 10'd321, 10'd360, 10'd401, 10'd442, 10'd483, 10'd525,
        10'd567, 10'd609, 10'd650, 10'd692, 10'd733, 10'd773, 10'd812, 10'd849,
        10'd885, 10'd919, 10'd951, 10'd979, 10'd1001, 10'd1014, 10'd1020, 10'd1022,
        10'd1023};

    localparam logic [9:0] TBL_SPRING [NSAMPLES] = '{
        10'd0, 10'd120, 10'd246, 10'd370, 10'd490, 10'd600, 10'd698, 10'd784,
        10'd856, 10'd916, 10'd962, 10'd994, 10'd1012, 10'd1020, 10'd1023, 10'd1023,
        10'd1023, 10'd1023, 10'd1023, 10'd1023, 10'd1023, 10'd1023, 10'd1023, 10'd1023,
        10'd1023, 10'd1023, 10'd1022, 10'd1020, 10'd1018, 10'd1015, 10'd1012, 10'd1008,
        10'd1023};

    // selectors 2 and 3 fall back to the spring curve
    function automatic logic [9:0] curve_entry(input logic [1:0] sel, input logic [5:0] i);
        logic [9:0] v;
        case (sel)
            CURVE_OUT: v = TBL_OUT[i];
            CURVE_IN: v = TBL_IN[i];
            default: v = TBL_SPRING[i];
        endcase
        return v;
    endfunction

    typedef struct packed {
        logic byp;
        logic signed [POS_W-1:0] bval;
        logic [IDX_W-1:0] idx;
        logic [DUR_W-1:0] rem;
    } seg_t;

    typedef struct packed {
        logic byp;
        logic signed [POS_W-1:0] bval;
        logic [Q10_W-1:0] prog;
    } prog_t;

endpackage

/* sv/bei_front.sv */
module bei_front
    import bei_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic [DUR_W-1:0] dur,
    input  logic signed [POS_W-1:0] start_pos,
    input  logic signed [POS_W-1:0] end_pos,
    input  logic in_valid,
    output logic in_ready,
    input  logic signed [TIME_W-1:0] t_in,
    output logic out_valid,
    input  logic out_ready,
    output seg_t out_seg
);

    localparam int NST = NDIV_IDX + 1;

    logic v_reg [NST];
    logic en [NST];
    logic byp_reg [NST];
    logic signed [POS_W-1:0] bval_reg [NST];
    logic [DUR_W-1:0] p_reg [NST];
    logic [IDX_W-1:0] q_reg [NST];
    logic [DUR_W-1:0] p_next [NST];
    logic [IDX_W-1:0] q_next [NST];
    logic end_hit;
    logic start_hit;

    // stall chain: a stage moves when empty or when the next one moves
    always_comb
    begin
        en[NST-1] = !v_reg[NST-1] || out_ready;
        for (int i = NST - 2; i >= 0; i--)
        begin
            en[i] = !v_reg[i] || en[i+1];
        end
    end

    assign in_ready = en[0];

    // end test before start test
    assign end_hit = t_in >= $signed({1'b0, dur});
    assign start_hit = t_in <= $signed(TIME_W'(0));

    // one quotient bit per stage after stage 0; partial remainder stays below dur
    always_comb
    begin
        logic [DUR_W:0] p2;
        p_next[0] = t_in[DUR_W-1:0];
        q_next[0] = '0;
        for (int i = 1; i < NST; i++)
        begin
            p2 = {p_reg[i-1], 1'b0};
            if (p2 >= {1'b0, dur})
            begin
                p_next[i] = DUR_W'(p2 - {1'b0, dur});
                q_next[i] = {q_reg[i-1][IDX_W-2:0], 1'b1};
            end
            else
            begin
                p_next[i] = p2[DUR_W-1:0];
                q_next[i] = {q_reg[i-1][IDX_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NST; i++)
            begin
                v_reg[i] <= 1'b0;
            end
        end
        else
        begin
            if (en[0])
            begin
                v_reg[0] <= in_valid;
            end
            for (int i = 1; i < NST; i++)
            begin
                if (en[i])
                begin
                    v_reg[i] <= v_reg[i-1];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            byp_reg[0] <= end_hit || start_hit;
            bval_reg[0] <= end_hit ? end_pos : start_pos;
            p_reg[0] <= p_next[0];
            q_reg[0] <= q_next[0];
        end
        for (int i = 1; i < NST; i++)
        begin
            if (en[i])
            begin
                byp_reg[i] <= byp_reg[i-1];
                bval_reg[i] <= bval_reg[i-1];
                p_reg[i] <= p_next[i];
                q_reg[i] <= q_next[i];
            end
        end
    end

    assign out_valid = v_reg[NST-1];
    assign out_seg.byp = byp_reg[NST-1];
    assign out_seg.bval = bval_reg[NST-1];
    assign out_seg.idx = q_reg[NST-1];
    assign out_seg.rem = p_reg[NST-1];

endmodule

/* sv/bei_interp.sv */
module bei_interp
    import bei_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic [1:0] curve_sel,
    input  logic [DUR_W-1:0] dur,
    input  logic in_valid,
    output logic in_ready,
    input  seg_t in_seg,
    output logic out_valid,
    input  logic out_ready,
    output prog_t out_prog
);

    // stage 0 lookup, 1 product, 2..8 quotient bits, 9 progress
    localparam int NST = NDIV_FRAC + 3;
    localparam int MAG_W = 7;
    localparam int PROD_W = MAG_W + DUR_W;

    typedef struct packed {
        logic byp;
        logic signed [POS_W-1:0] bval;
        logic [Q10_W-1:0] a;
        logic neg;
    } ctl_t;

    logic v_reg [NST];
    logic en [NST];
    ctl_t ctl_reg [NST];
    ctl_t ctl0;
    logic [MAG_W-1:0] mag_reg;
    logic [DUR_W-1:0] rem_reg;
    logic [DUR_W-1:0] p_reg [NST-2];
    logic [NDIV_FRAC-1:0] lo_reg [NST-2];
    logic [NDIV_FRAC-1:0] q_reg [NST-2];
    logic [DUR_W-1:0] p_next [NST-2];
    logic [NDIV_FRAC-1:0] lo_next [NST-2];
    logic [NDIV_FRAC-1:0] q_next [NST-2];
    logic [PROD_W-1:0] prod;
    logic [Q10_W-1:0] ta;
    logic [Q10_W-1:0] tb;
    logic signed [Q10_W:0] diff;
    logic [Q10_W:0] prog_sum;
    logic [Q10_W-1:0] prog_reg;
    ctl_t cl;

    always_comb
    begin
        en[NST-1] = !v_reg[NST-1] || out_ready;
        for (int i = NST - 2; i >= 0; i--)
        begin
            en[i] = !v_reg[i] || en[i+1];
        end
    end

    assign in_ready = en[0];

    // neighboring table entries and the magnitude of their step
    assign ta = curve_entry(curve_sel, {1'b0, in_seg.idx});
    assign tb = curve_entry(curve_sel, 6'({1'b0, in_seg.idx} + 6'd1));
    assign diff = $signed({1'b0, tb}) - $signed({1'b0, ta});
    assign ctl0 = '{byp: in_seg.byp, bval: in_seg.bval, a: ta, neg: diff[Q10_W]};

    assign prod = PROD_W'(mag_reg) * PROD_W'(rem_reg);

    // product is below 128*dur: upper part seeds the remainder, low bits shift in
    always_comb
    begin
        logic [DUR_W:0] p2;
        p_next[0] = prod[PROD_W-1:NDIV_FRAC];
        lo_next[0] = prod[NDIV_FRAC-1:0];
        q_next[0] = '0;
        for (int i = 1; i < NST - 2; i++)
        begin
            p2 = {p_reg[i-1], lo_reg[i-1][NDIV_FRAC-1]};
            lo_next[i] = {lo_reg[i-1][NDIV_FRAC-2:0], 1'b0};
            if (p2 >= {1'b0, dur})
            begin
                p_next[i] = DUR_W'(p2 - {1'b0, dur});
                q_next[i] = {q_reg[i-1][NDIV_FRAC-2:0], 1'b1};
            end
            else
            begin
                p_next[i] = p2[DUR_W-1:0];
                q_next[i] = {q_reg[i-1][NDIV_FRAC-2:0], 1'b0};
            end
        end
    end

    // truncation toward zero: apply the sign to the floored magnitude
    assign cl = ctl_reg[NST-2];
    assign prog_sum = cl.neg ? ({1'b0, cl.a} - (Q10_W+1)'(q_reg[NST-3]))
                             : ({1'b0, cl.a} + (Q10_W+1)'(q_reg[NST-3]));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NST; i++)
            begin
                v_reg[i] <= 1'b0;
            end
        end
        else
        begin
            if (en[0])
            begin
                v_reg[0] <= in_valid;
            end
            for (int i = 1; i < NST; i++)
            begin
                if (en[i])
                begin
                    v_reg[i] <= v_reg[i-1];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            ctl_reg[0] <= ctl0;
            mag_reg <= diff[Q10_W] ? MAG_W'(-diff) : MAG_W'(diff);
            rem_reg <= in_seg.rem;
        end
        for (int i = 1; i < NST; i++)
        begin
            if (en[i])
            begin
                ctl_reg[i] <= ctl_reg[i-1];
            end
        end
        for (int i = 0; i < NST - 2; i++)
        begin
            if (en[i+1])
            begin
                p_reg[i] <= p_next[i];
                lo_reg[i] <= lo_next[i];
                q_reg[i] <= q_next[i];
            end
        end
        if (en[NST-1])
        begin
            prog_reg <= prog_sum[Q10_W-1:0];
        end
    end

    assign out_valid = v_reg[NST-1];
    assign out_prog.byp = ctl_reg[NST-1].byp;
    assign out_prog.bval = ctl_reg[NST-1].bval;
    assign out_prog.prog = prog_reg;

endmodule

/* sv/bei_scale.sv */
module bei_scale
    import bei_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic signed [POS_W-1:0] start_pos,
    input  logic signed [POS_W-1:0] end_pos,
    input  logic in_valid,
    output logic in_ready,
    input  prog_t in_prog,
    output logic out_valid,
    input  logic out_ready,
    output logic signed [POS_W-1:0] result
);

    localparam int NST = 3;
    localparam int X_W = POS_W + Q10_W;
    localparam int QE_W = X_W + 1 - Q10_W;
    localparam int R_W = 12;

    logic v_reg [NST];
    logic en [NST];
    logic byp_reg [NST-1];
    logic signed [POS_W-1:0] bval_reg [NST-1];
    logic neg_reg [NST-1];
    logic [X_W-1:0] x_reg;
    logic [QE_W-1:0] qe_reg;
    logic [R_W-1:0] r_reg;
    logic signed [POS_W:0] span;
    logic [POS_W-1:0] span_mag;
    logic [X_W:0] est_sum;
    logic [QE_W-1:0] qe;
    logic [X_W:0] r_full;
    logic [POS_W-1:0] q_fix;
    logic signed [POS_W-1:0] res_next;

    always_comb
    begin
        en[NST-1] = !v_reg[NST-1] || out_ready;
        for (int i = NST - 2; i >= 0; i--)
        begin
            en[i] = !v_reg[i] || en[i+1];
        end
    end

    assign in_ready = en[0];

    assign span = (POS_W+1)'(end_pos) - (POS_W+1)'(start_pos);
    assign span_mag = span[POS_W] ? POS_W'(-span) : POS_W'(span);

    // x/1023 estimated as x*(1 + 2^-10 + 2^-20)/1024, at most one short
    assign est_sum = (X_W+1)'(x_reg) + (X_W+1)'(x_reg >> 10) + (X_W+1)'(x_reg >> 20);
    assign qe = est_sum[X_W:Q10_W];
    assign r_full = (X_W+1)'(x_reg) - (((X_W+1)'(qe) << 10) - (X_W+1)'(qe));

    // final correction, sign and bypass selection
    always_comb
    begin
        if (r_reg >= R_W'(2 * Q10_FULL))
        begin
            q_fix = POS_W'(qe_reg + QE_W'(2));
        end
        else if (r_reg >= R_W'(Q10_FULL))
        begin
            q_fix = POS_W'(qe_reg + QE_W'(1));
        end
        else
        begin
            q_fix = POS_W'(qe_reg);
        end
        if (byp_reg[NST-2])
        begin
            res_next = bval_reg[NST-2];
        end
        else if (neg_reg[NST-2])
        begin
            res_next = start_pos - $signed(q_fix);
        end
        else
        begin
            res_next = start_pos + $signed(q_fix);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NST; i++)
            begin
                v_reg[i] <= 1'b0;
            end
        end
        else
        begin
            if (en[0])
            begin
                v_reg[0] <= in_valid;
            end
            for (int i = 1; i < NST; i++)
            begin
                if (en[i])
                begin
                    v_reg[i] <= v_reg[i-1];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            byp_reg[0] <= in_prog.byp;
            bval_reg[0] <= in_prog.bval;
            neg_reg[0] <= span[POS_W];
            x_reg <= X_W'(span_mag) * X_W'(in_prog.prog);
        end
        if (en[1])
        begin
            byp_reg[1] <= byp_reg[0];
            bval_reg[1] <= bval_reg[0];
            neg_reg[1] <= neg_reg[0];
            qe_reg <= qe;
            r_reg <= r_full[R_W-1:0];
        end
        if (en[2])
        begin
            result <= res_next;
        end
    end

    assign out_valid = v_reg[NST-1];

endmodule

/* sv/bezier_ease_lut_interpolator_unit.sv */
// Easing curve evaluator: one elapsed time in, one eased position out.
// Input channel: in_valid/in_ready with elapsed_time (signed, 21 bits).
// Output channel: out_valid/out_ready with eased_value (signed, 16 bits).
// Config port: cfg_we, cfg_index, cfg_data; index 0 curve select,
// 1 duration, 2 start position, 3 end position. Write only while idle.
// Throughput: one item per cycle while the output is not stalled. The
// pipeline is built from the bit-per-stage dividers (5 stages for the
// segment index, 7 for the interpolation fraction) plus lookup,
// multiply and the divide-by-1023 stages.
// Every stage holds when the stage after it is full and stalled; empty
// stages keep filling, so input is taken while a result waits as long as
// some stage ahead is free. Nothing is dropped or repeated on a stall.
// Reset clears all valid bits and sets every config register to zero.
module bezier_ease_lut_interpolator_unit
    import bei_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic cfg_we,
    input  logic [1:0] cfg_index,
    input  logic [DUR_W-1:0] cfg_data,
    input  logic in_valid,
    output logic in_ready,
    input  logic signed [TIME_W-1:0] elapsed_time,
    output logic out_valid,
    input  logic out_ready,
    output logic signed [POS_W-1:0] eased_value
);

`include "assert_macros.svh"

    logic [1:0] curve_reg;
    logic [DUR_W-1:0] dur_reg;
    logic signed [POS_W-1:0] start_reg;
    logic signed [POS_W-1:0] end_reg;
    logic seg_valid;
    logic seg_ready;
    seg_t seg;
    logic prog_valid;
    logic prog_ready;
    prog_t prog;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            curve_reg <= '0;
            dur_reg <= '0;
            start_reg <= '0;
            end_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_CURVE: curve_reg <= cfg_data[1:0];
                CFG_DURATION: dur_reg <= cfg_data;
                CFG_START: start_reg <= cfg_data[POS_W-1:0];
                CFG_END: end_reg <= cfg_data[POS_W-1:0];
                default: ;
            endcase
        end
    end

    bei_front u_front (
        .clk(clk), .rst_n(rst_n), .dur(dur_reg),
        .start_pos(start_reg), .end_pos(end_reg),
        .in_valid(in_valid), .in_ready(in_ready), .t_in(elapsed_time),
        .out_valid(seg_valid), .out_ready(seg_ready), .out_seg(seg)
    );

    bei_interp u_interp (
        .clk(clk), .rst_n(rst_n), .curve_sel(curve_reg), .dur(dur_reg),
        .in_valid(seg_valid), .in_ready(seg_ready), .in_seg(seg),
        .out_valid(prog_valid), .out_ready(prog_ready), .out_prog(prog)
    );

    bei_scale u_scale (
        .clk(clk), .rst_n(rst_n), .start_pos(start_reg), .end_pos(end_reg),
        .in_valid(prog_valid), .in_ready(prog_ready), .in_prog(prog),
        .out_valid(out_valid), .out_ready(out_ready), .result(eased_value)
    );

    // an empty output register means every stage can move
    `BEI_CHECK(a_ready_when_empty, !out_valid |-> in_ready)
    // a stalled segment item stays put
    `BEI_CHECK_NEXT(a_seg_hold, seg_valid && !seg_ready, seg_valid && $stable(seg))
    // a stalled progress item stays put
    `BEI_CHECK_NEXT(a_prog_hold, prog_valid && !prog_ready, prog_valid && $stable(prog))

endmodule
